// ===== hdl/prmm_pkg.sv =====
// Package for the polyline ribbon mesher: payload types, codes, states and helpers.
package prmm_pkg;

    typedef struct packed {
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic               end_of_line;
    } in_item_t;

    typedef struct packed {
        logic [1:0]         kind;
        logic signed [31:0] vert_x;
        logic signed [31:0] vert_y;
        logic [31:0]        tex_u;
        logic [1:0]         tex_v_code;
        logic [31:0]        vert_index;
        logic [31:0]        tri_a;
        logic [31:0]        tri_b;
        logic [31:0]        tri_c;
        logic [31:0]        line_length;
        logic               degenerate;
        logic               last_of_run;
    } out_item_t;

    localparam logic [1:0] KIND_VERTEX   = 2'd0;
    localparam logic [1:0] KIND_TRIANGLE = 2'd1;
    localparam logic [1:0] KIND_SUMMARY  = 2'd2;

    localparam logic [1:0] TEXV_RIGHT = 2'd0;
    localparam logic [1:0] TEXV_HUB   = 2'd1;
    localparam logic [1:0] TEXV_LEFT  = 2'd2;

    localparam logic [1:0] REG_RIBBON_WIDTH   = 2'd0;
    localparam logic [1:0] REG_STRETCH_LIMIT  = 2'd1;
    localparam logic [1:0] REG_TEXTURE_ENABLE = 2'd2;
    localparam logic [1:0] REG_VERTEX_BASE    = 2'd3;

    localparam logic [23:0] RESET_RIBBON_WIDTH  = 24'd262144;
    localparam logic [15:0] RESET_STRETCH_LIMIT = 16'd1024;

    // Below this denominator the corner is treated as a hairpin.
    localparam logic signed [35:0] HAIRPIN_EPS = 36'sd429497;
    localparam logic signed [67:0] STRETCH_NUM = 68'sh1FFFFFFFFFFFF;
    localparam logic [63:0]        ONE_Q16     = 64'd65536;

    localparam logic signed [42:0] SAT_MAX = 43'sd2147483647;
    localparam logic signed [42:0] SAT_MIN = -43'sd2147483648;

    typedef enum logic [5:0] {
        ST_IDLE, ST_DIFF, ST_SQX, ST_SQY, ST_SUM, ST_SQRT, ST_DXL, ST_DYL, ST_DIV,
        ST_JOIN, ST_EPX, ST_EPY, ST_EPR, ST_IM1, ST_IM2, ST_IM3, ST_IM4, ST_IM5,
        ST_IM6, ST_IM7, ST_MX, ST_MXD, ST_MY, ST_MYD, ST_BX1, ST_BX2, ST_BX3,
        ST_BX4, ST_BXR, ST_EMIT, ST_UPD, ST_SUMM
    } state_t;

    typedef enum logic [1:0] {
        TGT_DX, TGT_DY, TGT_OX, TGT_OY
    } div_tgt_t;

    typedef enum logic [1:0] {
        EM_PAIR, EM_PAIR_SEG, EM_BEVEL
    } emit_mode_t;

    // Signed product times W over 2^17, rounded half away from zero.
    function automatic logic signed [41:0] rnd17(input logic signed [67:0] p);
        logic [67:0] a;
        logic [67:0] q;
        a = p[67] ? 68'(-p) : 68'(p);
        q = (a + 68'd65536) >> 17;
        rnd17 = p[67] ? -$signed(q[41:0]) : $signed(q[41:0]);
    endfunction

    function automatic logic signed [31:0] sat_add(input logic signed [31:0] b,
                                                   input logic signed [41:0] o);
        logic signed [42:0] s;
        s = 43'(b) + 43'(o);
        if (s > SAT_MAX)
            sat_add = 32'sh7FFFFFFF;
        else if (s < SAT_MIN)
            sat_add = 32'sh80000000;
        else
            sat_add = $signed(s[31:0]);
    endfunction

endpackage

// ===== hdl/polyline_ribbon_mitre_mesher_unit.sv =====
// Top level of the polyline ribbon mesher: sequencer, shared multiplier and iterative unit.
//
// Spine points enter on the in_valid/in_ready request channel, one per accept.
// Ribbon vertices, triangles and a summary leave on out_valid/out_ready, one per cycle
// at most, through a single output register. A point is meshed when the next point
// arrives; the point flagged end_of_line also emits its end pair, the last segment
// triangles and the summary. A request yields 0 to 14 results.
// The cost is set by one 35x33 signed multiplier used in turn, a bit-serial square root
// of 32 steps per edge, and a restoring divider of 64 steps run twice per edge of
// nonzero length and twice more at a mitre corner. in_ready is high only when the
// sequencer is idle. When out_ready is low the sequencer holds at the pending result
// and resumes when it is taken; nothing is dropped. Reset clears the line state, loads
// the default register values and leaves the output empty. Registers are written on
// cfg_write; the user must write them only while no point is in work, as the block
// itself does not enforce it.
module polyline_ribbon_mitre_mesher_unit (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  prmm_pkg::in_item_t   in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output prmm_pkg::out_item_t  out_data,
    input  logic                 cfg_write,
    input  logic [1:0]           cfg_index,
    input  logic [31:0]          cfg_data
);

    prmm_pkg::state_t     state_reg, state_next;
    prmm_pkg::div_tgt_t   div_tgt_reg;
    prmm_pkg::state_t     div_ret_reg;
    prmm_pkg::emit_mode_t emit_mode_reg;

    logic [23:0] ribbon_width_reg;
    logic [15:0] stretch_limit_reg;
    logic        texture_enable_reg;
    logic [31:0] vertex_base_reg;

    logic signed [31:0] prev_x_reg, prev_y_reg;
    logic signed [17:0] din_x_reg, din_y_reg;
    logic signed [17:0] dn_x_reg, dn_y_reg;
    logic [31:0] length_reg;
    logic [1:0]  points_seen_reg;
    logic [31:0] ring_l_reg, ring_r_reg;
    logic [31:0] next_vertex_reg;

    logic signed [31:0] px_reg, py_reg;
    logic        eol_reg;
    logic        eol_phase_reg;
    logic [31:0] ax_reg, ay_reg;
    logic        ex_neg_reg, ey_neg_reg;
    logic        small_reg;
    logic [63:0] qa_reg;
    logic [33:0] len_reg;

    logic signed [35:0] dot_reg, cross_reg, denom_reg;
    logic signed [41:0] off1x_reg, off1y_reg, off2x_reg, off2y_reg;

    logic [63:0] sq_v_reg, sq_r_reg, sq_bit_reg;
    logic [63:0] div_nq_reg;
    logic [33:0] div_rem_reg, div_d_reg;
    logic        div_neg_reg;
    logic [5:0]  cnt_reg;

    logic [3:0]  emit_step_reg;
    logic [31:0] emit_base_reg;

    logic signed [34:0] mul_a;
    logic signed [32:0] mul_b;
    logic signed [67:0] mul_p_reg;

    logic             out_valid_reg;
    prmm_pkg::out_item_t out_reg;
    prmm_pkg::out_item_t item;

    logic can_load, item_load, last_step, is_vtx, is_tri, vtx_neg, vtx_hub, vtx_off2;
    logic [1:0]  vtx_code;
    logic [31:0] ta, tb, tc;
    logic signed [41:0] ox, oy;

    logic signed [32:0] ex, ey;
    logic [64:0] sum65;
    logic [63:0] sq_trial, sq_v_n, sq_r_n;
    logic        sq_ge;
    logic [34:0] div_sh;
    logic        div_ge;
    logic [33:0] div_rem_n;
    logic [63:0] div_nq_n;
    logic [16:0] uq;
    logic [63:0] abs_p;
    logic        bevel_now;
    logic [34:0] len_sum;

    assign in_ready  = (state_reg == prmm_pkg::ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;
    assign can_load  = !out_valid_reg || out_ready;

    // Shared arithmetic: edge difference, root step, divide step, mitre test and length sum.
    always_comb
    begin
        ex = 33'(px_reg) - 33'(prev_x_reg);
        ey = 33'(py_reg) - 33'(prev_y_reg);
        sum65 = 65'(qa_reg) + 65'(mul_p_reg[63:0]);
        sq_trial = sq_r_reg + sq_bit_reg;
        sq_ge = (sq_v_reg >= sq_trial);
        sq_v_n = sq_ge ? (sq_v_reg - sq_trial) : sq_v_reg;
        sq_r_n = sq_ge ? ((sq_r_reg >> 1) + sq_bit_reg) : (sq_r_reg >> 1);
        div_sh = {div_rem_reg, div_nq_reg[63]};
        div_ge = (div_sh >= {1'b0, div_d_reg});
        div_rem_n = div_ge ? 34'(div_sh - {1'b0, div_d_reg}) : div_sh[33:0];
        div_nq_n = {div_nq_reg[62:0], div_ge};
        uq = (div_nq_n > prmm_pkg::ONE_Q16) ? 17'd65536 : div_nq_n[16:0];
        abs_p = mul_p_reg[67] ? 64'(-mul_p_reg) : mul_p_reg[63:0];
        bevel_now = (denom_reg < prmm_pkg::HAIRPIN_EPS) || (stretch_limit_reg == 16'd0)
                    || (mul_p_reg <= prmm_pkg::STRETCH_NUM);
        len_sum = 35'(length_reg) + 35'(len_reg);
    end

    // Multiplier operand selection.
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            prmm_pkg::ST_SQX: begin mul_a = 35'(ax_reg); mul_b = 33'(ax_reg); end
            prmm_pkg::ST_SQY: begin mul_a = 35'(ay_reg); mul_b = 33'(ay_reg); end
            prmm_pkg::ST_EPX: begin mul_a = 35'(-19'(dn_y_reg)); mul_b = 33'(ribbon_width_reg); end
            prmm_pkg::ST_EPY: begin mul_a = 35'(dn_x_reg); mul_b = 33'(ribbon_width_reg); end
            prmm_pkg::ST_IM1: begin mul_a = 35'(din_x_reg); mul_b = 33'(dn_x_reg); end
            prmm_pkg::ST_IM2: begin mul_a = 35'(din_y_reg); mul_b = 33'(dn_y_reg); end
            prmm_pkg::ST_IM3: begin mul_a = 35'(din_x_reg); mul_b = 33'(dn_y_reg); end
            prmm_pkg::ST_IM4: begin mul_a = 35'(din_y_reg); mul_b = 33'(dn_x_reg); end
            prmm_pkg::ST_IM5:
            begin
                mul_a = 35'(stretch_limit_reg);
                mul_b = 33'(stretch_limit_reg);
            end
            prmm_pkg::ST_IM6:
            begin
                mul_a = denom_reg[34:0];
                mul_b = $signed({1'b0, mul_p_reg[31:0]});
            end
            prmm_pkg::ST_MX:
            begin
                mul_a = 35'(-(19'(din_y_reg) + 19'(dn_y_reg)));
                mul_b = 33'(ribbon_width_reg);
            end
            prmm_pkg::ST_MY:
            begin
                mul_a = 35'(19'(din_x_reg) + 19'(dn_x_reg));
                mul_b = 33'(ribbon_width_reg);
            end
            prmm_pkg::ST_BX1: begin mul_a = 35'(-19'(din_y_reg)); mul_b = 33'(ribbon_width_reg); end
            prmm_pkg::ST_BX2: begin mul_a = 35'(din_x_reg); mul_b = 33'(ribbon_width_reg); end
            prmm_pkg::ST_BX3: begin mul_a = 35'(-19'(dn_y_reg)); mul_b = 33'(ribbon_width_reg); end
            prmm_pkg::ST_BX4: begin mul_a = 35'(dn_x_reg); mul_b = 33'(ribbon_width_reg); end
            default: ;
        endcase
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            prmm_pkg::ST_IDLE:
                if (in_valid)
                    state_next = (points_seen_reg == 2'd0) ? prmm_pkg::ST_UPD : prmm_pkg::ST_DIFF;
            prmm_pkg::ST_DIFF: state_next = prmm_pkg::ST_SQX;
            prmm_pkg::ST_SQX:  state_next = prmm_pkg::ST_SQY;
            prmm_pkg::ST_SQY:  state_next = prmm_pkg::ST_SUM;
            prmm_pkg::ST_SUM:  state_next = prmm_pkg::ST_SQRT;
            prmm_pkg::ST_SQRT:
                if (cnt_reg == 6'd31)
                    state_next = prmm_pkg::ST_DXL;
            prmm_pkg::ST_DXL:
                state_next = (len_reg == 34'd0) ? prmm_pkg::ST_JOIN : prmm_pkg::ST_DIV;
            prmm_pkg::ST_DYL:  state_next = prmm_pkg::ST_DIV;
            prmm_pkg::ST_DIV:
                if (cnt_reg == 6'd63)
                    state_next = div_ret_reg;
            prmm_pkg::ST_JOIN:
                state_next = (points_seen_reg == 2'd1) ? prmm_pkg::ST_EPX : prmm_pkg::ST_IM1;
            prmm_pkg::ST_EPX:  state_next = prmm_pkg::ST_EPY;
            prmm_pkg::ST_EPY:  state_next = prmm_pkg::ST_EPR;
            prmm_pkg::ST_EPR:  state_next = prmm_pkg::ST_EMIT;
            prmm_pkg::ST_IM1:  state_next = prmm_pkg::ST_IM2;
            prmm_pkg::ST_IM2:  state_next = prmm_pkg::ST_IM3;
            prmm_pkg::ST_IM3:  state_next = prmm_pkg::ST_IM4;
            prmm_pkg::ST_IM4:  state_next = prmm_pkg::ST_IM5;
            prmm_pkg::ST_IM5:  state_next = prmm_pkg::ST_IM6;
            prmm_pkg::ST_IM6:  state_next = prmm_pkg::ST_IM7;
            prmm_pkg::ST_IM7:
                state_next = bevel_now ? prmm_pkg::ST_BX1 : prmm_pkg::ST_MX;
            prmm_pkg::ST_MX:   state_next = prmm_pkg::ST_MXD;
            prmm_pkg::ST_MXD:  state_next = prmm_pkg::ST_DIV;
            prmm_pkg::ST_MY:   state_next = prmm_pkg::ST_MYD;
            prmm_pkg::ST_MYD:  state_next = prmm_pkg::ST_DIV;
            prmm_pkg::ST_BX1:  state_next = prmm_pkg::ST_BX2;
            prmm_pkg::ST_BX2:  state_next = prmm_pkg::ST_BX3;
            prmm_pkg::ST_BX3:  state_next = prmm_pkg::ST_BX4;
            prmm_pkg::ST_BX4:  state_next = prmm_pkg::ST_BXR;
            prmm_pkg::ST_BXR:  state_next = prmm_pkg::ST_EMIT;
            prmm_pkg::ST_EMIT:
                if (can_load && last_step)
                    state_next = eol_phase_reg ? prmm_pkg::ST_SUMM : prmm_pkg::ST_UPD;
            prmm_pkg::ST_UPD:
                if (!eol_reg)
                    state_next = prmm_pkg::ST_IDLE;
                else
                    state_next = (points_seen_reg != 2'd0) ? prmm_pkg::ST_EPX : prmm_pkg::ST_SUMM;
            prmm_pkg::ST_SUMM:
                if (can_load)
                    state_next = prmm_pkg::ST_IDLE;
            default: state_next = prmm_pkg::ST_IDLE;
        endcase
    end

    // Result item for the current emit step or the summary.
    always_comb
    begin
        item      = '0;
        last_step = 1'b0;
        is_vtx    = 1'b0;
        is_tri    = 1'b0;
        vtx_neg   = 1'b0;
        vtx_hub   = 1'b0;
        vtx_off2  = 1'b0;
        vtx_code  = prmm_pkg::TEXV_LEFT;
        ta = '0;
        tb = '0;
        tc = '0;
        unique case (emit_mode_reg)
            prmm_pkg::EM_BEVEL:
            begin
                unique case (emit_step_reg)
                    4'd0: begin is_vtx = 1'b1; vtx_hub = 1'b1; vtx_code = prmm_pkg::TEXV_HUB; end
                    4'd1: is_vtx = 1'b1;
                    4'd2: begin is_vtx = 1'b1; vtx_neg = 1'b1; vtx_code = prmm_pkg::TEXV_RIGHT; end
                    4'd3: begin is_vtx = 1'b1; vtx_off2 = 1'b1; end
                    4'd4:
                    begin
                        is_vtx = 1'b1;
                        vtx_off2 = 1'b1;
                        vtx_neg = 1'b1;
                        vtx_code = prmm_pkg::TEXV_RIGHT;
                    end
                    4'd5:
                    begin
                        // Left cap, wound by the turn direction.
                        is_tri = 1'b1;
                        tb = emit_base_reg;
                        ta = !cross_reg[35] ? emit_base_reg + 32'd3 : emit_base_reg + 32'd1;
                        tc = !cross_reg[35] ? emit_base_reg + 32'd1 : emit_base_reg + 32'd3;
                    end
                    4'd6:
                    begin
                        is_tri = 1'b1;
                        tb = emit_base_reg;
                        ta = !cross_reg[35] ? emit_base_reg + 32'd4 : emit_base_reg + 32'd2;
                        tc = !cross_reg[35] ? emit_base_reg + 32'd2 : emit_base_reg + 32'd4;
                    end
                    4'd7:
                    begin
                        is_tri = 1'b1;
                        ta = ring_l_reg; tb = ring_r_reg; tc = emit_base_reg + 32'd2;
                    end
                    4'd8:
                    begin
                        is_tri = 1'b1;
                        last_step = 1'b1;
                        ta = ring_l_reg; tb = emit_base_reg + 32'd2; tc = emit_base_reg + 32'd1;
                    end
                    default: ;
                endcase
            end
            default:
            begin
                unique case (emit_step_reg)
                    4'd0: is_vtx = 1'b1;
                    4'd1:
                    begin
                        is_vtx = 1'b1;
                        vtx_neg = 1'b1;
                        vtx_code = prmm_pkg::TEXV_RIGHT;
                        last_step = (emit_mode_reg == prmm_pkg::EM_PAIR);
                    end
                    4'd2:
                    begin
                        is_tri = 1'b1;
                        ta = ring_l_reg; tb = ring_r_reg; tc = emit_base_reg + 32'd1;
                    end
                    4'd3:
                    begin
                        is_tri = 1'b1;
                        last_step = 1'b1;
                        ta = ring_l_reg; tb = emit_base_reg + 32'd1; tc = emit_base_reg;
                    end
                    default: ;
                endcase
            end
        endcase

        ox = vtx_off2 ? off2x_reg : off1x_reg;
        oy = vtx_off2 ? off2y_reg : off1y_reg;
        if (vtx_hub)
        begin
            ox = '0;
            oy = '0;
        end
        if (vtx_neg)
        begin
            ox = -ox;
            oy = -oy;
        end

        if (state_reg == prmm_pkg::ST_SUMM)
        begin
            item.kind        = prmm_pkg::KIND_SUMMARY;
            item.line_length = (points_seen_reg == 2'd0) ? 32'd0 : length_reg;
            item.degenerate  = (points_seen_reg == 2'd0) || (length_reg == 32'd0);
            item.last_of_run = 1'b1;
        end
        else if (is_vtx)
        begin
            item.kind        = prmm_pkg::KIND_VERTEX;
            item.vert_x      = prmm_pkg::sat_add(prev_x_reg, ox);
            item.vert_y      = prmm_pkg::sat_add(prev_y_reg, oy);
            item.tex_u       = texture_enable_reg ? length_reg : 32'd0;
            item.tex_v_code  = texture_enable_reg ? vtx_code : prmm_pkg::TEXV_RIGHT;
            item.vert_index  = next_vertex_reg;
            item.last_of_run = last_step && !eol_reg;
        end
        else if (is_tri)
        begin
            item.kind        = prmm_pkg::KIND_TRIANGLE;
            item.tri_a       = ta;
            item.tri_b       = tb;
            item.tri_c       = tc;
            item.last_of_run = last_step && !eol_reg;
        end
    end

    assign item_load = can_load
                       && (state_reg == prmm_pkg::ST_EMIT || state_reg == prmm_pkg::ST_SUMM);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (item_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_load)
            out_reg <= item;
        mul_p_reg <= mul_a * mul_b;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ribbon_width_reg   <= prmm_pkg::RESET_RIBBON_WIDTH;
            stretch_limit_reg  <= prmm_pkg::RESET_STRETCH_LIMIT;
            texture_enable_reg <= 1'b1;
            vertex_base_reg    <= 32'd0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                prmm_pkg::REG_RIBBON_WIDTH:   ribbon_width_reg   <= cfg_data[23:0];
                prmm_pkg::REG_STRETCH_LIMIT:  stretch_limit_reg  <= cfg_data[15:0];
                prmm_pkg::REG_TEXTURE_ENABLE: texture_enable_reg <= cfg_data[0];
                prmm_pkg::REG_VERTEX_BASE:    vertex_base_reg    <= cfg_data;
                default: ;
            endcase
        end
    end

    // Control and line state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= prmm_pkg::ST_IDLE;
            prev_x_reg      <= '0;
            prev_y_reg      <= '0;
            din_x_reg       <= '0;
            din_y_reg       <= '0;
            length_reg      <= '0;
            points_seen_reg <= '0;
            ring_l_reg      <= '0;
            ring_r_reg      <= '0;
            next_vertex_reg <= '0;
            eol_phase_reg   <= 1'b0;
            emit_step_reg   <= '0;
            cnt_reg         <= '0;
            div_ret_reg     <= prmm_pkg::ST_IDLE;
            div_tgt_reg     <= prmm_pkg::TGT_DX;
            emit_mode_reg   <= prmm_pkg::EM_PAIR;
        end
        else
        begin
            state_reg <= state_next;
            unique case (state_reg)
                prmm_pkg::ST_IDLE:
                    if (in_valid)
                    begin
                        eol_phase_reg <= 1'b0;
                        if (points_seen_reg == 2'd0)
                        begin
                            next_vertex_reg <= vertex_base_reg;
                            length_reg      <= 32'd0;
                        end
                    end
                prmm_pkg::ST_SUM:
                    cnt_reg <= '0;
                prmm_pkg::ST_SQRT:
                    cnt_reg <= cnt_reg + 6'd1;
                prmm_pkg::ST_DXL:
                begin
                    cnt_reg     <= '0;
                    div_tgt_reg <= prmm_pkg::TGT_DX;
                    div_ret_reg <= prmm_pkg::ST_DYL;
                end
                prmm_pkg::ST_DYL:
                begin
                    cnt_reg     <= '0;
                    div_tgt_reg <= prmm_pkg::TGT_DY;
                    div_ret_reg <= prmm_pkg::ST_JOIN;
                end
                prmm_pkg::ST_MXD:
                begin
                    cnt_reg     <= '0;
                    div_tgt_reg <= prmm_pkg::TGT_OX;
                    div_ret_reg <= prmm_pkg::ST_MY;
                end
                prmm_pkg::ST_MYD:
                begin
                    cnt_reg     <= '0;
                    div_tgt_reg <= prmm_pkg::TGT_OY;
                    div_ret_reg <= prmm_pkg::ST_EMIT;
                end
                prmm_pkg::ST_DIV:
                    cnt_reg <= cnt_reg + 6'd1;
                prmm_pkg::ST_JOIN:
                begin
                    emit_step_reg <= '0;
                    emit_mode_reg <= prmm_pkg::EM_PAIR;
                end
                prmm_pkg::ST_IM7:
                    emit_mode_reg <= bevel_now ? prmm_pkg::EM_BEVEL : prmm_pkg::EM_PAIR_SEG;
                prmm_pkg::ST_EMIT:
                    if (can_load)
                    begin
                        emit_step_reg <= emit_step_reg + 4'd1;
                        if (is_vtx)
                            next_vertex_reg <= next_vertex_reg + 32'd1;
                        if (last_step)
                        begin
                            if (emit_mode_reg == prmm_pkg::EM_BEVEL)
                            begin
                                ring_l_reg <= emit_base_reg + 32'd3;
                                ring_r_reg <= emit_base_reg + 32'd4;
                            end
                            else
                            begin
                                ring_l_reg <= emit_base_reg;
                                ring_r_reg <= emit_base_reg + 32'd1;
                            end
                        end
                    end
                prmm_pkg::ST_UPD:
                begin
                    if (points_seen_reg != 2'd0)
                    begin
                        length_reg <= (len_sum > 35'h0FFFFFFFF) ? 32'hFFFFFFFF : len_sum[31:0];
                        din_x_reg  <= dn_x_reg;
                        din_y_reg  <= dn_y_reg;
                    end
                    prev_x_reg <= px_reg;
                    prev_y_reg <= py_reg;
                    if (eol_reg)
                    begin
                        eol_phase_reg <= 1'b1;
                        emit_mode_reg <= prmm_pkg::EM_PAIR_SEG;
                        emit_step_reg <= '0;
                    end
                    else
                    begin
                        points_seen_reg <= (points_seen_reg == 2'd0) ? 2'd1 : 2'd2;
                    end
                end
                prmm_pkg::ST_SUMM:
                    if (can_load)
                        points_seen_reg <= 2'd0;
                default: ;
            endcase
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            prmm_pkg::ST_IDLE:
                if (in_valid)
                begin
                    px_reg  <= in_data.point_x;
                    py_reg  <= in_data.point_y;
                    eol_reg <= in_data.end_of_line;
                end
            prmm_pkg::ST_DIFF:
            begin
                ax_reg     <= ex[32] ? 32'(-ex) : ex[31:0];
                ay_reg     <= ey[32] ? 32'(-ey) : ey[31:0];
                ex_neg_reg <= ex[32];
                ey_neg_reg <= ey[32];
            end
            prmm_pkg::ST_SQY:
                qa_reg <= mul_p_reg[63:0];
            prmm_pkg::ST_SUM:
            begin
                small_reg  <= !ax_reg[31] && !ay_reg[31];
                sq_v_reg   <= (!ax_reg[31] && !ay_reg[31]) ? sum65[63:0] : sum65[64:2];
                sq_r_reg   <= '0;
                sq_bit_reg <= 64'h4000000000000000;
            end
            prmm_pkg::ST_SQRT:
            begin
                sq_v_reg   <= sq_v_n;
                sq_r_reg   <= sq_r_n;
                sq_bit_reg <= sq_bit_reg >> 2;
                if (cnt_reg == 6'd31)
                    len_reg <= small_reg ? {2'b00, sq_r_n[31:0]} : {1'b0, sq_r_n[31:0], 1'b0};
            end
            prmm_pkg::ST_DXL:
            begin
                if (len_reg == 34'd0)
                begin
                    dn_x_reg <= '0;
                    dn_y_reg <= '0;
                end
                div_nq_reg  <= {16'd0, ax_reg, 16'd0} + 64'(len_reg >> 1);
                div_d_reg   <= len_reg;
                div_rem_reg <= '0;
                div_neg_reg <= ex_neg_reg;
            end
            prmm_pkg::ST_DYL:
            begin
                div_nq_reg  <= {16'd0, ay_reg, 16'd0} + 64'(len_reg >> 1);
                div_d_reg   <= len_reg;
                div_rem_reg <= '0;
                div_neg_reg <= ey_neg_reg;
            end
            prmm_pkg::ST_MXD, prmm_pkg::ST_MYD:
            begin
                div_nq_reg  <= (abs_p << 15) + 64'(denom_reg[33:1]);
                div_d_reg   <= denom_reg[33:0];
                div_rem_reg <= '0;
                div_neg_reg <= mul_p_reg[67];
            end
            prmm_pkg::ST_DIV:
            begin
                div_nq_reg  <= div_nq_n;
                div_rem_reg <= div_rem_n;
                if (cnt_reg == 6'd63)
                begin
                    unique case (div_tgt_reg)
                        prmm_pkg::TGT_DX:
                            dn_x_reg <= div_neg_reg ? -$signed({1'b0, uq}) : $signed({1'b0, uq});
                        prmm_pkg::TGT_DY:
                            dn_y_reg <= div_neg_reg ? -$signed({1'b0, uq}) : $signed({1'b0, uq});
                        prmm_pkg::TGT_OX:
                            off1x_reg <= div_neg_reg ? -$signed({2'b00, div_nq_n[39:0]})
                                                     : $signed({2'b00, div_nq_n[39:0]});
                        prmm_pkg::TGT_OY:
                            off1y_reg <= div_neg_reg ? -$signed({2'b00, div_nq_n[39:0]})
                                                     : $signed({2'b00, div_nq_n[39:0]});
                        default: ;
                    endcase
                end
            end
            prmm_pkg::ST_EPY: off1x_reg <= prmm_pkg::rnd17(mul_p_reg);
            prmm_pkg::ST_EPR: off1y_reg <= prmm_pkg::rnd17(mul_p_reg);
            prmm_pkg::ST_IM2: dot_reg <= 36'(mul_p_reg);
            prmm_pkg::ST_IM3: dot_reg <= dot_reg + 36'(mul_p_reg);
            prmm_pkg::ST_IM4: cross_reg <= 36'(mul_p_reg);
            prmm_pkg::ST_IM5:
            begin
                cross_reg <= cross_reg - 36'(mul_p_reg);
                denom_reg <= 36'sh100000000 + dot_reg;
            end
            prmm_pkg::ST_BX2: off1x_reg <= prmm_pkg::rnd17(mul_p_reg);
            prmm_pkg::ST_BX3: off1y_reg <= prmm_pkg::rnd17(mul_p_reg);
            prmm_pkg::ST_BX4: off2x_reg <= prmm_pkg::rnd17(mul_p_reg);
            prmm_pkg::ST_BXR: off2y_reg <= prmm_pkg::rnd17(mul_p_reg);
            prmm_pkg::ST_EMIT:
                if (can_load && emit_step_reg == 4'd0)
                    emit_base_reg <= next_vertex_reg;
            default: ;
        endcase
    end

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("block took a second request while busy");

    a_summary_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.kind == prmm_pkg::KIND_SUMMARY) |-> out_data.last_of_run)
        else $error("summary is not the final result of its request");

    a_pair_steps: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == prmm_pkg::ST_EMIT && emit_mode_reg == prmm_pkg::EM_PAIR)
        |-> (emit_step_reg < 4'd2))
        else $error("endpoint pair ran past its two vertices");

    a_points_seen: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == prmm_pkg::ST_JOIN) |-> (points_seen_reg != 2'd0))
        else $error("join reached without a previous point");

endmodule
